### src/psgb_pkg.sv
`timescale 1ns / 1ps

package psgb_pkg;

    // One particle as it enters the block.
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [30:0]        life_left;
        logic [16:0]        time_step;
        logic signed [31:0] wind_x;
        logic signed [31:0] wind_y;
        logic signed [31:0] wind_z;
    } t_in;

    // One updated particle.
    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_pos_z;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic [30:0]        new_life;
        logic               expired;
    } t_out;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRAG     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESTIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRICTION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_H  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_X  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_Z  = 3'd6;

    localparam logic [30:0]        RST_GRAVITY  = 31'd642253;
    localparam logic [30:0]        RST_DRAG     = 31'd0;
    localparam logic [16:0]        RST_RESTIT   = 17'd32768;
    localparam logic [20:0]        RST_FRICTION = 21'd26214;
    localparam logic signed [31:0] RST_FLOOR_H  = 32'sd0;
    localparam logic [63:0]        RST_FLOOR_X  = 64'd0;
    localparam logic [63:0]        RST_FLOOR_Z  = 64'd0;

endpackage

### src/psgb_isqrt.sv
`timescale 1ns / 1ps

module psgb_isqrt #(
    parameter int W  = 64,
    parameter int PW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [W-1:0]    i_n,
    input  logic [PW-1:0]   i_pay,
    output logic            o_vld,
    output logic [W/2-1:0]  o_root,
    output logic [PW-1:0]   o_pay
);
    localparam int S = W / 2;

    // One root bit per stage, restoring method.
    logic          r_vld  [S];
    logic [W-1:0]  r_n    [S];
    logic [S:0]    r_rem  [S];
    logic [S-1:0]  r_root [S];
    logic [PW-1:0] r_pay  [S];

    genvar k;
    generate
        for (k = 0; k < S; k++) begin : g_stage
            logic          vi;
            logic [W-1:0]  ni;
            logic [S:0]    remi;
            logic [S-1:0]  rooti;
            logic [PW-1:0] payi;
            logic [S+2:0]  rem_sh;
            logic [S+2:0]  trial;
            logic [S+2:0]  diff;
            logic          ge;
            logic [S:0]    n_rem;
            logic [S-1:0]  n_root;

            if (k == 0) begin : g_first
                assign vi    = i_vld;
                assign ni    = i_n;
                assign remi  = '0;
                assign rooti = '0;
                assign payi  = i_pay;
            end else begin : g_next
                assign vi    = r_vld[k-1];
                assign ni    = r_n[k-1];
                assign remi  = r_rem[k-1];
                assign rooti = r_root[k-1];
                assign payi  = r_pay[k-1];
            end

            assign rem_sh = {remi, ni[W-1:W-2]};
            assign trial  = {1'b0, rooti, 2'b01};
            assign diff   = rem_sh - trial;
            assign ge     = (rem_sh >= trial);
            assign n_rem  = ge ? diff[S:0] : rem_sh[S:0];
            assign n_root = {rooti[S-2:0], ge};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= vi;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_n[k]    <= {ni[W-3:0], 2'b00};
                    r_rem[k]  <= n_rem;
                    r_root[k] <= n_root;
                    r_pay[k]  <= payi;
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[S-1];
    assign o_root = r_root[S-1];
    assign o_pay  = r_pay[S-1];

endmodule

### src/psgb_scale_div.sv
`timescale 1ns / 1ps

module psgb_scale_div #(
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [63:0]   i_num_a,
    input  logic [63:0]   i_num_b,
    input  logic [31:0]   i_den,
    input  logic [PW-1:0] i_pay,
    output logic          o_vld,
    output logic [31:0]   o_quo_a,
    output logic [31:0]   o_quo_b,
    output logic [PW-1:0] o_pay
);
    localparam int QW = 32;

    // Two lanes sharing one divisor, one quotient bit per stage. The upper
    // half of each numerator is below the divisor, so the quotient fits.
    logic          r_vld   [QW];
    logic [QW-1:0] r_den   [QW];
    logic [QW-1:0] r_rem_a [QW];
    logic [QW-1:0] r_rem_b [QW];
    logic [QW-1:0] r_lo_a  [QW];
    logic [QW-1:0] r_lo_b  [QW];
    logic [QW-1:0] r_q_a   [QW];
    logic [QW-1:0] r_q_b   [QW];
    logic [PW-1:0] r_pay   [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            logic          vi;
            logic [QW-1:0] deni;
            logic [QW-1:0] rai;
            logic [QW-1:0] rbi;
            logic [QW-1:0] lai;
            logic [QW-1:0] lbi;
            logic [QW-1:0] qai;
            logic [QW-1:0] qbi;
            logic [PW-1:0] payi;
            logic [QW:0]   sh_a;
            logic [QW:0]   sh_b;
            logic [QW:0]   df_a;
            logic [QW:0]   df_b;
            logic          ge_a;
            logic          ge_b;

            if (k == 0) begin : g_first
                assign vi   = i_vld;
                assign deni = i_den;
                assign rai  = i_num_a[63:32];
                assign rbi  = i_num_b[63:32];
                assign lai  = i_num_a[31:0];
                assign lbi  = i_num_b[31:0];
                assign qai  = '0;
                assign qbi  = '0;
                assign payi = i_pay;
            end else begin : g_next
                assign vi   = r_vld[k-1];
                assign deni = r_den[k-1];
                assign rai  = r_rem_a[k-1];
                assign rbi  = r_rem_b[k-1];
                assign lai  = r_lo_a[k-1];
                assign lbi  = r_lo_b[k-1];
                assign qai  = r_q_a[k-1];
                assign qbi  = r_q_b[k-1];
                assign payi = r_pay[k-1];
            end

            assign sh_a = {rai, lai[QW-1]};
            assign sh_b = {rbi, lbi[QW-1]};
            assign df_a = sh_a - {1'b0, deni};
            assign df_b = sh_b - {1'b0, deni};
            assign ge_a = (sh_a >= {1'b0, deni});
            assign ge_b = (sh_b >= {1'b0, deni});

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= vi;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[k]   <= deni;
                    r_rem_a[k] <= ge_a ? df_a[QW-1:0] : sh_a[QW-1:0];
                    r_rem_b[k] <= ge_b ? df_b[QW-1:0] : sh_b[QW-1:0];
                    r_lo_a[k]  <= {lai[QW-2:0], 1'b0};
                    r_lo_b[k]  <= {lbi[QW-2:0], 1'b0};
                    r_q_a[k]   <= {qai[QW-2:0], ge_a};
                    r_q_b[k]   <= {qbi[QW-2:0], ge_b};
                    r_pay[k]   <= payi;
                end
            end
        end
    endgenerate

    assign o_vld   = r_vld[QW-1];
    assign o_quo_a = r_q_a[QW-1];
    assign o_quo_b = r_q_b[QW-1];
    assign o_pay   = r_pay[QW-1];

endmodule

### src/particle_step_with_ground_bounce_top.sv
`timescale 1ns / 1ps
// An accepted word runs through the stage registers, the two square roots and the divider,
// these three giving one bit per stage, and reaches o_out through the output buffer.
// Throughput: one particle per cycle; a two-word output buffer lets input continue
// while a result waits, and the whole pipeline holds only when both entries are full.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults.
module particle_step_with_ground_bounce_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  psgb_pkg::t_in                     i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output psgb_pkg::t_out                    o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [psgb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [psgb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import psgb_pkg::*;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [2:0][31:0] rel;
        logic [16:0]      dt;
        logic [30:0]      life;
        logic             expd;
        logic             contact;
        logic [31:0]      py_b;
        logic [31:0]      vy_b;
        logic [33:0]      j;
        logic [31:0]      vt;
        logic [31:0]      scl;
    } t_ctx;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'h7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

    // Configuration registers.
    logic [30:0]        r_gravity;
    logic [30:0]        r_drag;
    logic [16:0]        r_restit;
    logic [20:0]        r_friction;
    logic signed [31:0] r_floor_h;
    logic [63:0]        r_floor_x;
    logic [63:0]        r_floor_z;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity  <= RST_GRAVITY;
            r_drag     <= RST_DRAG;
            r_restit   <= RST_RESTIT;
            r_friction <= RST_FRICTION;
            r_floor_h  <= RST_FLOOR_H;
            r_floor_x  <= RST_FLOOR_X;
            r_floor_z  <= RST_FLOOR_Z;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_GRAVITY:  r_gravity  <= i_cfg_data[30:0];
                REG_DRAG:     r_drag     <= i_cfg_data[30:0];
                REG_RESTIT:   r_restit   <= i_cfg_data[16:0];
                REG_FRICTION: r_friction <= i_cfg_data[20:0];
                REG_FLOOR_H:  r_floor_h  <= $signed(i_cfg_data[31:0]);
                REG_FLOOR_X:  r_floor_x  <= i_cfg_data;
                REG_FLOOR_Z:  r_floor_z  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advance: held only while both output buffer entries are full.
    logic en;
    logic r_o0_vld;
    logic r_o1_vld;

    assign en         = !r_o1_vld || i_out_ready;
    assign o_in_ready = en;

    // Stage registers.
    t_in                r_a;
    t_ctx               r_b, r_c, r_d, r_e, r_f, r_g, r_h, r_i, r_j, r_k, r_l, r_n, r_o, r_p;
    logic               r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld, r_f_vld, r_g_vld;
    logic               r_h_vld, r_i_vld, r_j_vld, r_k_vld, r_l_vld, r_n_vld, r_o_vld;
    logic               r_p_vld;
    logic [63:0]        r_c_sq [3];
    logic [62:0]        r_d_kp;
    logic [30:0]        r_e_k;
    logic signed [63:0] r_f_pr [3];
    logic [2:0][31:0]   r_g_acc;
    logic signed [49:0] r_h_pr [3];
    logic signed [49:0] r_j_pr [3];
    logic [63:0]        r_l_sq [2];
    logic [54:0]        r_n_loss;
    logic [63:0]        r_p_mx;
    logic [63:0]        r_p_mz;

    // Stage A: expiry, life and relative air velocity.
    t_ctx a_ctx;
    always_comb begin
        a_ctx        = '0;
        a_ctx.pos[0] = r_a.pos_x;
        a_ctx.pos[1] = r_a.pos_y;
        a_ctx.pos[2] = r_a.pos_z;
        a_ctx.vel[0] = r_a.vel_x;
        a_ctx.vel[1] = r_a.vel_y;
        a_ctx.vel[2] = r_a.vel_z;
        a_ctx.rel[0] = sat32(64'(r_a.vel_x) - 64'(r_a.wind_x));
        a_ctx.rel[1] = sat32(64'(r_a.vel_y) - 64'(r_a.wind_y));
        a_ctx.rel[2] = sat32(64'(r_a.vel_z) - 64'(r_a.wind_z));
        a_ctx.dt     = r_a.time_step;
        a_ctx.expd   = (r_a.life_left < {14'd0, r_a.time_step});
        a_ctx.life   = a_ctx.expd ? 31'd0 : (r_a.life_left - {14'd0, r_a.time_step});
    end

    // Stage B: squares of the relative speed components.
    logic [63:0] b_sq [3];
    logic [31:0] b_m  [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            b_m[i]  = mag32(r_b.rel[i]);
            b_sq[i] = b_m[i] * b_m[i];
        end
    end

    logic [63:0] c_sum;
    assign c_sum = r_c_sq[0] + r_c_sq[1] + r_c_sq[2];

    logic        s1_vld;
    logic [31:0] s1_root;
    t_ctx        s1_pay;

    psgb_isqrt #(
        .W  (64),
        .PW ($bits(t_ctx))
    ) u_rel_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_c_vld),
        .i_n     (c_sum),
        .i_pay   (r_c),
        .o_vld   (s1_vld),
        .o_root  (s1_root),
        .o_pay   (s1_pay)
    );

    // Stage E: drag gain, saturated.
    logic [30:0] e_k;
    assign e_k = (r_d_kp[62:47] != 16'd0) ? 31'h7fff_ffff : r_d_kp[46:16];

    // Stage F: drag products per component.
    logic signed [63:0] f_pr [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            f_pr[i] = $signed({1'b0, r_e_k}) * $signed(r_e.rel[i]);
        end
    end

    // Stage G: acceleration, gravity acting on y.
    logic [2:0][31:0] g_acc;
    logic signed [63:0] g_t [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            g_t[i] = -(r_f_pr[i] >>> 16);
        end
        g_t[1] = g_t[1] - $signed({33'd0, r_gravity});
        for (int i = 0; i < 3; i++) begin
            g_acc[i] = sat32(g_t[i]);
        end
    end

    // Stage H: a * dt.
    logic signed [49:0] h_pr [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            h_pr[i] = $signed(r_g_acc[i]) * $signed({1'b0, r_g.dt});
        end
    end

    // Stage I: velocity update; an expired particle keeps its inputs.
    t_ctx i_ctx;
    always_comb begin
        i_ctx = r_h;
        for (int i = 0; i < 3; i++) begin
            if (!r_h.expd) begin
                i_ctx.vel[i] = sat32(64'($signed(r_h.vel[i])) + 64'(r_h_pr[i] >>> 16));
            end
        end
    end

    // Stage J: v * dt.
    logic signed [49:0] j_pr [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            j_pr[i] = $signed(r_i.vel[i]) * $signed({1'b0, r_i.dt});
        end
    end

    // Stage K: position update.
    t_ctx k_ctx;
    always_comb begin
        k_ctx = r_j;
        for (int i = 0; i < 3; i++) begin
            if (!r_j.expd) begin
                k_ctx.pos[i] = sat32(64'($signed(r_j.pos[i])) + 64'(r_j_pr[i] >>> 16));
            end
        end
    end

    // Stage L: floor contact, reflected height, bounce speed and impulse.
    t_ctx        l_ctx;
    logic [31:0] l_ay;
    logic [31:0] l_mx;
    logic [31:0] l_mz;
    logic [63:0] l_sqx;
    logic [63:0] l_sqz;
    logic [48:0] l_pb;
    logic [49:0] l_pj;
    logic        l_in_x;
    logic        l_in_z;
    always_comb begin
        l_ctx  = r_k;
        l_ay   = mag32(r_k.vel[1]);
        l_mx   = mag32(r_k.vel[0]);
        l_mz   = mag32(r_k.vel[2]);
        l_sqx  = l_mx * l_mx;
        l_sqz  = l_mz * l_mz;
        l_in_x = ($signed(r_k.pos[0]) >= $signed(r_floor_x[31:0]))
              && ($signed(r_k.pos[0]) <= $signed(r_floor_x[63:32]));
        l_in_z = ($signed(r_k.pos[2]) >= $signed(r_floor_z[31:0]))
              && ($signed(r_k.pos[2]) <= $signed(r_floor_z[63:32]));
        l_ctx.contact = !r_k.expd && l_in_x && l_in_z
                     && ($signed(r_k.pos[1]) <= r_floor_h);
        if ($signed(r_k.vel[1]) < 32'sd1) begin
            l_ctx.py_b = sat32(64'(r_floor_h) + 64'sd1);
        end else begin
            l_ctx.py_b = sat32(64'(r_floor_h) + 64'(r_floor_h)
                               - 64'($signed(r_k.pos[1])) + 64'sd1);
        end
        l_pb = 49'(l_ay) * 49'(r_restit);
        l_ctx.vy_b = (l_pb[48:47] != 2'd0) ? 32'h7fff_ffff : {1'b0, l_pb[46:16]};
        l_pj = 50'(l_ay) * 50'(18'(r_restit) + 18'd65536);
        l_ctx.j = l_pj[49:16];
    end

    logic [63:0] l_sum;
    assign l_sum = r_l_sq[0] + r_l_sq[1];

    logic        s2_vld;
    logic [31:0] s2_root;
    t_ctx        s2_pay;

    psgb_isqrt #(
        .W  (64),
        .PW ($bits(t_ctx))
    ) u_tan_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_l_vld),
        .i_n     (l_sum),
        .i_pay   (r_l),
        .o_vld   (s2_vld),
        .o_root  (s2_root),
        .o_pay   (s2_pay)
    );

    t_ctx n_ctx;
    always_comb begin
        n_ctx    = s2_pay;
        n_ctx.vt = s2_root;
    end

    // Stage O: tangential speed after friction, floored at zero.
    t_ctx        o_ctx;
    logic [38:0] o_loss;
    always_comb begin
        o_ctx  = r_n;
        o_loss = r_n_loss[54:16];
        o_ctx.scl = (o_loss >= {7'd0, r_n.vt}) ? 32'd0 : (r_n.vt - o_loss[31:0]);
    end

    // Stage P: numerators |v| * t.
    logic [31:0] p_mx;
    logic [31:0] p_mz;
    logic [63:0] p_prx;
    logic [63:0] p_prz;
    always_comb begin
        p_mx  = mag32(r_o.vel[0]);
        p_mz  = mag32(r_o.vel[2]);
        p_prx = p_mx * r_o.scl;
        p_prz = p_mz * r_o.scl;
    end

    logic        d_vld;
    logic [31:0] d_qx;
    logic [31:0] d_qz;
    t_ctx        d_pay;

    psgb_scale_div #(
        .PW ($bits(t_ctx))
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_p_vld),
        .i_num_a (r_p_mx),
        .i_num_b (r_p_mz),
        .i_den   (r_p.vt),
        .i_pay   (r_p),
        .o_vld   (d_vld),
        .o_quo_a (d_qx),
        .o_quo_b (d_qz),
        .o_pay   (d_pay)
    );

    // Final selection of the result word.
    t_out fin;
    logic scale;
    always_comb begin
        scale         = d_pay.contact && (d_pay.vt > 32'd1);
        fin.new_pos_x = $signed(d_pay.pos[0]);
        fin.new_pos_y = $signed(d_pay.contact ? d_pay.py_b : d_pay.pos[1]);
        fin.new_pos_z = $signed(d_pay.pos[2]);
        if (scale) begin
            fin.new_vel_x = $signed(d_pay.vel[0][31] ? (~d_qx + 32'd1) : d_qx);
            fin.new_vel_z = $signed(d_pay.vel[2][31] ? (~d_qz + 32'd1) : d_qz);
        end else begin
            fin.new_vel_x = $signed(d_pay.vel[0]);
            fin.new_vel_z = $signed(d_pay.vel[2]);
        end
        fin.new_vel_y = $signed(d_pay.contact ? d_pay.vy_b : d_pay.vel[1]);
        fin.new_life  = d_pay.life;
        fin.expired   = d_pay.expd;
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
            r_i_vld <= 1'b0;
            r_j_vld <= 1'b0;
            r_k_vld <= 1'b0;
            r_l_vld <= 1'b0;
            r_n_vld <= 1'b0;
            r_o_vld <= 1'b0;
            r_p_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_in_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= s1_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
            r_h_vld <= r_g_vld;
            r_i_vld <= r_h_vld;
            r_j_vld <= r_i_vld;
            r_k_vld <= r_j_vld;
            r_l_vld <= r_k_vld;
            r_n_vld <= s2_vld;
            r_o_vld <= r_n_vld;
            r_p_vld <= r_o_vld;
        end
    end

    // Stage data.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a      <= i_in;
            r_b      <= a_ctx;
            r_c      <= r_b;
            r_c_sq   <= b_sq;
            r_d      <= s1_pay;
            r_d_kp   <= r_drag * s1_root;
            r_e      <= r_d;
            r_e_k    <= e_k;
            r_f      <= r_e;
            r_f_pr   <= f_pr;
            r_g      <= r_f;
            r_g_acc  <= g_acc;
            r_h      <= r_g;
            r_h_pr   <= h_pr;
            r_i      <= i_ctx;
            r_j      <= r_i;
            r_j_pr   <= j_pr;
            r_k      <= k_ctx;
            r_l      <= l_ctx;
            r_l_sq   <= '{l_sqx, l_sqz};
            r_n      <= n_ctx;
            r_n_loss <= 55'(r_friction) * 55'(n_ctx.j);
            r_o      <= o_ctx;
            r_p      <= r_o;
            r_p_mx   <= p_prx;
            r_p_mz   <= p_prz;
        end
    end

    // Two-word output buffer; entry 0 is the word on display.
    t_out r_o0;
    t_out r_o1;
    logic push;
    logic pop;

    assign push = d_vld && en;
    assign pop  = r_o0_vld && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o0_vld <= 1'b0;
            r_o1_vld <= 1'b0;
        end else if (pop) begin
            if (r_o1_vld) begin
                r_o0     <= r_o1;
                r_o1     <= fin;
                r_o1_vld <= push;
            end else begin
                r_o0     <= fin;
                r_o0_vld <= push;
            end
        end else if (!r_o0_vld) begin
            r_o0     <= fin;
            r_o0_vld <= push;
        end else if (push) begin
            r_o1     <= fin;
            r_o1_vld <= 1'b1;
        end
    end

    assign o_out_valid = r_o0_vld;
    assign o_out       = r_o0;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import psgb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam longint Q_ONE = 65536;
    localparam int DRAIN_CYCLES = 140;

    typedef struct {
        t_in item;
        bit  drain_first;
    } t_pending;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in                   i_in;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out                  o_out;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    particle_step_with_ground_bounce_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Local copy of the block's registers.
    longint unsigned m_gravity, m_drag, m_restit, m_friction;
    longint          m_floor_h;
    logic [63:0]     m_floor_x, m_floor_z;

    t_pending particle_q[$];
    t_out     expected_q[$];
    int       n_mismatch;
    int       n_results;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root, bit_w;
        root = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > n) bit_w >>= 2;
        while (bit_w != 0) begin
            if (n >= root + bit_w) begin
                n = n - (root + bit_w);
                root = (root >> 1) + bit_w;
            end else begin
                root >>= 1;
            end
            bit_w >>= 2;
        end
        return root;
    endfunction

    function automatic longint scale_toward_zero(longint v, longint unsigned num,
                                                 longint unsigned den);
        longint unsigned m;
        m = (magnitude(v) * num) / den;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        case (idx)
            REG_GRAVITY:  m_gravity  = 64'(data[30:0]);
            REG_DRAG:     m_drag     = 64'(data[30:0]);
            REG_RESTIT:   m_restit   = 64'(data[16:0]);
            REG_FRICTION: m_friction = 64'(data[20:0]);
            REG_FLOOR_H:  m_floor_h  = longint'($signed(data[31:0]));
            REG_FLOOR_X:  m_floor_x  = data;
            REG_FLOOR_Z:  m_floor_z  = data;
            default: ;
        endcase
    endfunction

    function automatic t_out step_particle(t_in x);
        t_out            res;
        longint          p[3], v[3], w[3], r[3];
        longint          acc, dt, vy;
        longint unsigned sq, len, gain, ay, vt, j, loss, t;
        longint          xmin, xmax, zmin, zmax;
        p[0] = x.pos_x;  p[1] = x.pos_y;  p[2] = x.pos_z;
        v[0] = x.vel_x;  v[1] = x.vel_y;  v[2] = x.vel_z;
        w[0] = x.wind_x; w[1] = x.wind_y; w[2] = x.wind_z;
        dt = longint'(x.time_step);
        res.new_life = '0;
        res.expired  = 1'b0;
        if (x.life_left < x.time_step) begin
            res.expired = 1'b1;
        end else begin
            res.new_life = x.life_left - x.time_step;
            sq = 0;
            for (int i = 0; i < 3; i++) begin
                r[i] = sat32(v[i] - w[i]);
                sq += magnitude(r[i]) * magnitude(r[i]);
            end
            len = int_sqrt(sq);
            gain = (m_drag * len) >> 16;
            if (gain > 64'h7FFF_FFFF) gain = 64'h7FFF_FFFF;
            for (int i = 0; i < 3; i++) begin
                acc = -((longint'(gain) * r[i]) >>> 16);
                if (i == 1) acc -= longint'(m_gravity);
                acc  = sat32(acc);
                v[i] = sat32(v[i] + ((acc * dt) >>> 16));
                p[i] = sat32(p[i] + ((v[i] * dt) >>> 16));
            end
            xmin = longint'($signed(m_floor_x[31:0]));
            xmax = longint'($signed(m_floor_x[63:32]));
            zmin = longint'($signed(m_floor_z[31:0]));
            zmax = longint'($signed(m_floor_z[63:32]));
            if (p[0] >= xmin && p[0] <= xmax && p[2] >= zmin && p[2] <= zmax
                    && p[1] <= m_floor_h) begin
                vy = v[1];
                ay = magnitude(vy);
                if (vy < 1) p[1] = sat32(m_floor_h + 1);
                else        p[1] = sat32(2 * m_floor_h - p[1] + 1);
                vt = int_sqrt(magnitude(v[0]) * magnitude(v[0])
                              + magnitude(v[2]) * magnitude(v[2]));
                if (vt > 1) begin
                    j    = (ay * (longint'(Q_ONE) + m_restit)) >> 16;
                    loss = (m_friction * j) >> 16;
                    t    = (loss >= vt) ? 0 : vt - loss;
                    v[0] = scale_toward_zero(v[0], t, vt);
                    v[2] = scale_toward_zero(v[2], t, vt);
                end
                v[1] = sat32(longint'((ay * m_restit) >> 16));
            end
        end
        res.new_pos_x = p[0][31:0];
        res.new_pos_y = p[1][31:0];
        res.new_pos_z = p[2][31:0];
        res.new_vel_x = v[0][31:0];
        res.new_vel_y = v[1][31:0];
        res.new_vel_z = v[2][31:0];
        return res;
    endfunction

    // ---------------------------------------------------------------- clock, limit
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

    // ---------------------------------------------------------------- sender
    int  burst_left;
    int  gap_left;
    bit  in_taken;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left <= 1;
            gap_left   <= 0;
        end else if (!i_in_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (particle_q.size() > 0 &&
                         !(particle_q[0].drain_first && expected_q.size() != 0)) begin
                i_in       <= particle_q[0].item;
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    case ($urandom_range(0, 9))
                        0:       begin burst_left <= 200; gap_left <= 0; end
                        1:       begin burst_left <= $urandom_range(1, 30);
                                       gap_left   <= $urandom_range(5, 40); end
                        default: begin burst_left <= $urandom_range(1, 30);
                                       gap_left   <= $urandom_range(0, 3); end
                    endcase
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // The word on the input is taken here; its expected result is formed at once.
    always @(posedge i_clk) begin
        in_taken = 1'b0;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            expected_q.push_back(step_particle(i_in));
            void'(particle_q.pop_front());
            in_taken = 1'b1;
        end
    end

    // ---------------------------------------------------------------- receiver
    int  stall_mode;
    int  mode_left;
    int  hold_left;
    bit  hold_done;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_mode  <= 0;
            mode_left   <= 0;
            hold_left   <= 0;
            hold_done   <= 1'b0;
        end else if (!hold_done && n_results == 300) begin
            // One long hold-off so that the pipeline and its buffer fill up.
            hold_done   <= 1'b1;
            hold_left   <= 500;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(20, 120);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= 1'($urandom_range(0, 1));
                2:       i_out_ready <= ($urandom_range(0, 3) != 0);
                default: i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ---------------------------------------------------------------- checker
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results <= n_results + 1;
            if (expected_q.size() == 0) begin
                n_mismatch = n_mismatch + 1;
                if (n_mismatch <= 10)
                    $display("ERROR: unexpected result word %p", o_out);
            end else begin
                want = expected_q.pop_front();
                if (o_out.new_pos_x !== want.new_pos_x || o_out.new_pos_y !== want.new_pos_y
                        || o_out.new_pos_z !== want.new_pos_z
                        || o_out.new_vel_x !== want.new_vel_x
                        || o_out.new_vel_y !== want.new_vel_y
                        || o_out.new_vel_z !== want.new_vel_z
                        || o_out.new_life !== want.new_life
                        || o_out.expired !== want.expired) begin
                    n_mismatch = n_mismatch + 1;
                    if (n_mismatch <= 10)
                        $display("ERROR: result %0d expected %p got %p",
                                 n_results, want, o_out);
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus
    function automatic logic [31:0] near(longint centre, longint span);
        longint off;
        off = longint'($urandom_range(0, 2 * span)) - span;
        return 32'(sat32(centre + off));
    endfunction

    function automatic t_in random_particle();
        t_in x;
        logic [63:0] xr, zr;
        if ($urandom_range(0, 4) == 0) begin
            x.pos_x  = $urandom; x.pos_y  = $urandom; x.pos_z  = $urandom;
            x.vel_x  = $urandom; x.vel_y  = $urandom; x.vel_z  = $urandom;
            x.wind_x = $urandom; x.wind_y = $urandom; x.wind_z = $urandom;
            x.life_left = 31'($urandom);
            x.time_step = 17'($urandom);
        end else begin
            xr = m_floor_x;
            zr = m_floor_z;
            if ($signed(xr[31:0]) <= $signed(xr[63:32]) && $urandom_range(0, 1))
                x.pos_x = near(longint'($signed(xr[31:0])), 200 * Q_ONE);
            else
                x.pos_x = near(0, 150 * Q_ONE);
            x.pos_z  = ($urandom_range(0, 1)) ? near(longint'($signed(zr[63:32])), 200 * Q_ONE)
                                              : near(0, 150 * Q_ONE);
            x.pos_y  = near(m_floor_h, 10 * Q_ONE);
            x.vel_x  = near(0, 50 * Q_ONE);
            x.vel_y  = near(0, 50 * Q_ONE);
            x.vel_z  = near(0, 50 * Q_ONE);
            x.wind_x = near(0, 20 * Q_ONE);
            x.wind_y = near(0, 5 * Q_ONE);
            x.wind_z = near(0, 20 * Q_ONE);
            x.time_step = 17'($urandom_range(0, Q_ONE));
            if ($urandom_range(0, 7) == 0)
                x.life_left = 31'($urandom_range(0, x.time_step));
            else
                x.life_left = 31'(x.time_step + $urandom_range(0, 1 << 24));
        end
        return x;
    endfunction

    function automatic t_in make_particle(longint px, longint py, longint pz,
                                          longint vx, longint vy, longint vz,
                                          longint life, longint dt);
        t_in x;
        x.pos_x = 32'(px); x.pos_y = 32'(py); x.pos_z = 32'(pz);
        x.vel_x = 32'(vx); x.vel_y = 32'(vy); x.vel_z = 32'(vz);
        x.wind_x = '0; x.wind_y = '0; x.wind_z = '0;
        x.life_left = 31'(life);
        x.time_step = 17'(dt);
        return x;
    endfunction

    task automatic queue_particle(t_in x, bit drain_first = 1'b0);
        t_pending e;
        e.item = x;
        e.drain_first = drain_first;
        particle_q.push_back(e);
    endtask

    task automatic queue_random(int count);
        for (int n = 0; n < count; n++)
            queue_particle(random_particle(), n == count / 2);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_register(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (particle_q.size() != 0 || i_in_valid || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_in x;
        n_mismatch  = 0;
        n_results   = 0;
        i_rst_n     = 1'b0;
        i_in        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        m_gravity   = 64'(RST_GRAVITY);
        m_drag      = 64'(RST_DRAG);
        m_restit    = 64'(RST_RESTIT);
        m_friction  = 64'(RST_FRICTION);
        m_floor_h   = longint'(RST_FLOOR_H);
        m_floor_x   = RST_FLOOR_X;
        m_floor_z   = RST_FLOOR_Z;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed words under the reset settings: the floor is the single point x = z = 0.
        queue_particle(make_particle(0, 0, 0, 0, 0, 0, Q_ONE, 16'h4000));
        queue_particle(make_particle(0, Q_ONE, 0, 0, -5 * Q_ONE, 0, Q_ONE, Q_ONE));
        queue_particle(make_particle(0, -Q_ONE, 0, 0, 10 * Q_ONE, 0, Q_ONE, 100));
        queue_particle(make_particle(0, 0, 0, 5 * Q_ONE, -3 * Q_ONE, 2 * Q_ONE, 9, 0));
        queue_particle(make_particle(0, 0, 0, Q_ONE, -30000 * Q_ONE, 0, 9, 0));
        queue_particle(make_particle(0, 0, 0, 1, -Q_ONE, 0, 9, 0));
        queue_particle(make_particle(7, 8, 9, 1, 2, 3, 100, 101));
        queue_particle(make_particle(7, 8, 9, 1, 2, 3, 300, 300));
        queue_particle(make_particle(7, 8, 9, 1, 2, 3, 31'h7FFF_FFFF, 17'h1FFFF));
        queue_particle(make_particle(7, 8, 9, 1, 2, 3, 5, 0));
        x = '1;
        x.pos_x = 32'h7FFF_FFFF; x.pos_y = 32'h7FFF_FFFF; x.pos_z = 32'h7FFF_FFFF;
        x.vel_x = 32'h7FFF_FFFF; x.vel_y = 32'h7FFF_FFFF; x.vel_z = 32'h7FFF_FFFF;
        x.wind_x = 32'h8000_0000; x.wind_y = 32'h8000_0000; x.wind_z = 32'h8000_0000;
        x.time_step = 17'(Q_ONE);
        queue_particle(x);
        x = '0;
        x.pos_x = 32'h8000_0000; x.pos_y = 32'h8000_0000; x.pos_z = 32'h8000_0000;
        x.vel_x = 32'h8000_0000; x.vel_y = 32'h8000_0000; x.vel_z = 32'h8000_0000;
        x.wind_x = 32'h7FFF_FFFF; x.wind_y = 32'h7FFF_FFFF; x.wind_z = 32'h7FFF_FFFF;
        queue_particle(x);
        queue_particle(make_particle(0, 0, 0, 32'sh8000_0000, 32'sh8000_0000,
                                     32'sh8000_0000, 9, 0));
        queue_random(400);
        wait_idle();

        // Every register at its upper end; the floor covers the whole plane.
        write_register(REG_GRAVITY,  64'h7FFF_FFFF);
        write_register(REG_DRAG,     64'h7FFF_FFFF);
        write_register(REG_RESTIT,   64'h1FFFF);
        write_register(REG_FRICTION, 64'h1F_FFFF);
        write_register(REG_FLOOR_H,  64'h7FFF_FFFF);
        write_register(REG_FLOOR_X,  64'h7FFF_FFFF_8000_0000);
        write_register(REG_FLOOR_Z,  64'h7FFF_FFFF_8000_0000);
        write_register(REG_UNUSED,   64'hFFFF_FFFF_FFFF_FFFF);
        queue_particle(make_particle(0, 0, 0, 5 * Q_ONE, 3 * Q_ONE, 1, Q_ONE, Q_ONE));
        queue_particle(make_particle(0, -Q_ONE, 0, 5 * Q_ONE, -3 * Q_ONE, 1, Q_ONE, 0));
        queue_random(400);
        wait_idle();

        // Lower ends, with the floor ranges inverted so that nothing touches.
        write_register(REG_GRAVITY,  64'h0);
        write_register(REG_DRAG,     64'h0);
        write_register(REG_RESTIT,   64'h0);
        write_register(REG_FRICTION, 64'h0);
        write_register(REG_FLOOR_H,  64'h8000_0000);
        write_register(REG_FLOOR_X,  64'h0000_0000_0001_0000);
        write_register(REG_FLOOR_Z,  64'h8000_0000_7FFF_FFFF);
        queue_random(400);
        wait_idle();

        // Realistic settings with a bounded floor patch, redrawn several times.
        for (int ph = 0; ph < 4; ph++) begin
            write_register(REG_GRAVITY,  64'($urandom_range(0, 20 * Q_ONE)));
            write_register(REG_DRAG,     64'($urandom_range(0, 4000)));
            write_register(REG_RESTIT,   (ph == 0) ? 64'(Q_ONE)
                                                   : 64'($urandom_range(0, Q_ONE)));
            write_register(REG_FRICTION, 64'($urandom_range(0, 2 * Q_ONE)));
            write_register(REG_FLOOR_H,  {$urandom, $urandom} >> ($urandom_range(40, 63)));
            write_register(REG_FLOOR_X,  {32'(100 * Q_ONE), 32'(-100 * Q_ONE)});
            write_register(REG_FLOOR_Z,  {32'(80 * Q_ONE), 32'(-120 * Q_ONE)});
            queue_random(140);
            wait_idle();
        end

        if (n_mismatch == 0 && expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### files.f
src/psgb_pkg.sv
src/psgb_isqrt.sv
src/psgb_scale_div.sv
src/particle_step_with_ground_bounce_top.sv
tb/tb_top.sv
